FILE: rtl/core/ipc_pkg.sv
// Shared types, codes and the precedence table of the infix to postfix converter.
package ipc_pkg;

  // Character codes that frame an expression and name the operators.
  localparam logic [7:0] CHAR_ADD    = 8'h2B;
  localparam logic [7:0] CHAR_SUB    = 8'h2D;
  localparam logic [7:0] CHAR_MUL    = 8'h2A;
  localparam logic [7:0] CHAR_DIV    = 8'h2F;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_FRAME  = 8'h23;

  // Error codes carried with each result item.
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_PAREN    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_NO_FRAME = 2'd3;

  // Operator codes as held on the stack; OP_NONE marks an operand character.
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_LPAREN = 3'd4,
    OP_RPAREN = 3'd5,
    OP_FRAME  = 3'd6,
    OP_NONE   = 3'd7
  } op_code_t;

  // Relation between the stack top and the incoming operator.
  typedef enum logic [1:0] {
    REL_LT = 2'd0,
    REL_EQ = 2'd1,
    REL_GT = 2'd2,
    REL_ER = 2'd3
  } rel_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WORK = 1'b1
  } state_t;

  // Shift control for the chain of stack cells.
  typedef struct packed {
    logic     push;
    logic     pop;
    op_code_t code;
  } stk_ctl_t;

  function automatic op_code_t classify(input logic [7:0] c);
    op_code_t k;
    unique case (c)
      CHAR_ADD:    k = OP_ADD;
      CHAR_SUB:    k = OP_SUB;
      CHAR_MUL:    k = OP_MUL;
      CHAR_DIV:    k = OP_DIV;
      CHAR_LPAREN: k = OP_LPAREN;
      CHAR_RPAREN: k = OP_RPAREN;
      CHAR_FRAME:  k = OP_FRAME;
      default:     k = OP_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] op_char(input op_code_t k);
    logic [7:0] c;
    unique case (k)
      OP_ADD:    c = CHAR_ADD;
      OP_SUB:    c = CHAR_SUB;
      OP_MUL:    c = CHAR_MUL;
      OP_DIV:    c = CHAR_DIV;
      OP_LPAREN: c = CHAR_LPAREN;
      OP_RPAREN: c = CHAR_RPAREN;
      OP_FRAME:  c = CHAR_FRAME;
      default:   c = 8'd0;
    endcase
    return c;
  endfunction

  // Rows are the stack top, columns the incoming operator.
  function automatic rel_t prec(input op_code_t top, input op_code_t inc);
    rel_t r;
    unique case (top)
      OP_ADD, OP_SUB: begin
        case (inc)
          OP_MUL, OP_DIV, OP_LPAREN: r = REL_LT;
          default:                   r = REL_GT;
        endcase
      end
      OP_MUL, OP_DIV: begin
        r = (inc == OP_LPAREN) ? REL_LT : REL_GT;
      end
      OP_LPAREN: begin
        case (inc)
          OP_RPAREN: r = REL_EQ;
          OP_FRAME:  r = REL_ER;
          default:   r = REL_LT;
        endcase
      end
      OP_RPAREN: begin
        r = (inc == OP_LPAREN) ? REL_ER : REL_GT;
      end
      OP_FRAME: begin
        case (inc)
          OP_RPAREN: r = REL_ER;
          OP_FRAME:  r = REL_EQ;
          default:   r = REL_LT;
        endcase
      end
      default: r = REL_ER;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/infix_to_postfix_converter_unit.sv
// Infix to postfix converter: takes one expression character per item, framed by
// '#', and gives the postfix form. An operand, an opening '#' or a character outside
// a frame is handled when it is accepted. An operator or a closing '#' is first
// accepted, then pops and emits the stack operators one at a time and ends with a
// closing step for its push, match, error or end of expression, each step waiting
// while the output register is full; no new character is taken until it is done.
// The operator stack is a chain of STACK_DEPTH cells that all shift by one place
// on a push or pop. An expression that overflows the stack or has an unmatched
// parenthesis gives an error item and the block waits for a new opening '#'.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast,
  output logic [2:0] m_tuser    // [0] end_of_expression, [2:1] error_code
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  ipc_pkg::state_t   state;
  ipc_pkg::state_t   state_next;
  ipc_pkg::op_code_t cur_op;
  ipc_pkg::op_code_t cur_op_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              in_expr;
  logic              in_expr_next;

  ipc_pkg::stk_ctl_t ctl;
  ipc_pkg::op_code_t top;
  ipc_pkg::op_code_t second;
  ipc_pkg::op_code_t in_op;
  ipc_pkg::rel_t     rel;
  ipc_pkg::rel_t     rel_next;

  logic       out_free;
  logic       accept;
  logic       start;
  logic       finish;
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_last;
  logic       emit_eoe;
  logic [1:0] emit_err;
  logic       more;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ipc_pkg::ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign in_op    = ipc_pkg::classify(s_tdata);
  assign rel      = ipc_pkg::prec(top, cur_op);
  assign rel_next = ipc_pkg::prec(second, cur_op);

  // Whether another item follows once the top operator is popped and emitted.
  always_comb begin
    if (count == CW'(1)) begin
      more = (cur_op == ipc_pkg::OP_FRAME);
    end else begin
      more = (rel_next == ipc_pkg::REL_GT) || (rel_next == ipc_pkg::REL_ER) ||
             (cur_op == ipc_pkg::OP_FRAME);
    end
  end

  // Datapath actions for this cycle: result item, stack shift and counters.
  always_comb begin
    ctl          = '{push: 1'b0, pop: 1'b0, code: cur_op};
    count_next   = count;
    in_expr_next = in_expr;
    cur_op_next  = cur_op;
    start        = 1'b0;
    finish       = 1'b0;
    emit         = 1'b0;
    emit_char    = 8'd0;
    emit_last    = 1'b1;
    emit_eoe     = 1'b0;
    emit_err     = ipc_pkg::ERR_OK;

    if (state == ipc_pkg::ST_IDLE) begin
      if (accept) begin
        if (!in_expr) begin
          if (in_op == ipc_pkg::OP_FRAME) begin
            ctl          = '{push: 1'b1, pop: 1'b0, code: ipc_pkg::OP_FRAME};
            count_next   = CW'(1);
            in_expr_next = 1'b1;
          end else begin
            emit     = 1'b1;
            emit_err = ipc_pkg::ERR_NO_FRAME;
          end
        end else if (in_op == ipc_pkg::OP_NONE) begin
          emit      = 1'b1;
          emit_char = s_tdata;
        end else begin
          cur_op_next = in_op;
          start       = 1'b1;
        end
      end
    end else if (out_free) begin
      if (count != '0 && rel == ipc_pkg::REL_GT) begin
        // Pop and emit the stack top.
        emit       = 1'b1;
        emit_char  = ipc_pkg::op_char(top);
        emit_last  = !more;
        ctl.pop    = 1'b1;
        count_next = count - CW'(1);
      end else if (count != '0 && rel == ipc_pkg::REL_ER) begin
        // Unmatched parenthesis: drop the expression.
        emit         = 1'b1;
        emit_err     = ipc_pkg::ERR_PAREN;
        count_next   = '0;
        in_expr_next = 1'b0;
        finish       = 1'b1;
      end else begin
        finish = 1'b1;
        if (count != '0 && rel == ipc_pkg::REL_EQ) begin
          ctl.pop    = 1'b1;
          count_next = count - CW'(1);
        end
        if (cur_op == ipc_pkg::OP_FRAME) begin
          emit         = 1'b1;
          emit_eoe     = 1'b1;
          count_next   = '0;
          in_expr_next = 1'b0;
        end else if (cur_op == ipc_pkg::OP_RPAREN ||
                     (count != '0 && rel == ipc_pkg::REL_EQ)) begin
          // A closing parenthesis is dropped once its match is gone.
        end else if (count >= CW'(STACK_DEPTH)) begin
          emit         = 1'b1;
          emit_err     = ipc_pkg::ERR_OVERFLOW;
          count_next   = '0;
          in_expr_next = 1'b0;
        end else begin
          ctl.push   = 1'b1;
          count_next = count + CW'(1);
        end
      end
    end
  end

  // Next state of the operator sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ipc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = ipc_pkg::ST_WORK;
        end
      end
      ipc_pkg::ST_WORK: begin
        if (finish) begin
          state_next = ipc_pkg::ST_IDLE;
        end
      end
      default: state_next = ipc_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ipc_pkg::ST_IDLE;
      count   <= '0;
      in_expr <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      in_expr <= in_expr_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_op <= cur_op_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_char;
      m_tlast <= emit_last;
      m_tuser <= {emit_err, emit_eoe};
    end
  end

  ipc_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .ctl    (ctl),
    .top    (top),
    .second (second)
  );

endmodule

FILE: rtl/core/ipc_cell.sv
// One stack cell: holds one operator code and shifts toward or away from the top.
module ipc_cell (
  input  logic              clk,
  input  ipc_pkg::stk_ctl_t ctl,
  input  ipc_pkg::op_code_t push_in,
  input  ipc_pkg::op_code_t pop_in,
  output ipc_pkg::op_code_t code
);

  // A push takes the neighbor nearer the top, a pop the neighbor below.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      code <= push_in;
    end else if (ctl.pop) begin
      code <= pop_in;
    end
  end

endmodule

FILE: rtl/core/ipc_stack.sv
// Operator stack built as a row of shifting cells with the top in cell zero.
module ipc_stack #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  ipc_pkg::stk_ctl_t ctl,
  output ipc_pkg::op_code_t top,
  output ipc_pkg::op_code_t second
);

  ipc_pkg::op_code_t cells [STACK_DEPTH];

  // Cell zero takes the pushed code; the bottom cell takes a filler on a pop.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    ipc_pkg::op_code_t push_in;
    ipc_pkg::op_code_t pop_in;

    if (i == 0) begin : g_top
      assign push_in = ctl.code;
    end else begin : g_mid
      assign push_in = cells[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign pop_in = ipc_pkg::OP_NONE;
    end else begin : g_up
      assign pop_in = cells[i+1];
    end

    ipc_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .push_in (push_in),
      .pop_in  (pop_in),
      .code    (cells[i])
    );
  end

  assign top    = cells[0];
  assign second = cells[1];

endmodule
